// ----- sv/rrfp_pkg.sv -----
// Package for the range report frame parser.
// Holds frame layout constants and shared types; no dependencies.
package rrfp_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [4:0] pos_t;

  localparam int unsigned FrameLen     = 27;
  localparam int unsigned PayloadCount = 19;

  localparam pos_t POS_HDR0      = 5'd0;
  localparam pos_t POS_HDR1      = 5'd1;
  localparam pos_t POS_LEN       = 5'd2;
  localparam pos_t POS_ADDR      = 5'd3;
  localparam pos_t POS_CMD       = 5'd4;
  localparam pos_t POS_PAY_FIRST = 5'd5;
  localparam pos_t POS_PAY_LAST  = 5'd23;
  localparam pos_t POS_SUM_LAST  = 5'd24;
  localparam pos_t POS_TRL0      = 5'd25;
  localparam pos_t POS_TRL1      = 5'd26;

  localparam byte_t HDR0_BYTE   = 8'hAE;
  localparam byte_t HDR1_BYTE   = 8'hA7;
  localparam byte_t TRL0_BYTE   = 8'hBC;
  localparam byte_t TRL1_BYTE   = 8'hBE;
  localparam byte_t CMD_RANGE   = 8'h85;
  localparam byte_t LEN_MIN     = 8'd3;
  localparam byte_t LEN_MAX     = 8'd22;

endpackage

// ----- sv/range_report_frame_parser_unit.sv -----
// Range report frame parser: cuts a byte stream into 27-byte frames and
// reports the decoded measurements once per frame. Depends on rrfp_pkg.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid_i, in_ready_o, rx_byte_i         | in
//  output  | out_valid_o, out_ready_i, frame_ok_o,     | out
//          | nine 16-bit measurements, unit_code_o     |
//
// One byte is taken per cycle when ready; the frame position counter and checksum
// accumulator update in the cycle of each beat. The result of a frame is
// registered on the edge that accepts its 27th byte and shows the next cycle.
// in_ready_o drops only while a result waits and out_ready_i is low.
// Reset clears the position, checksum and flags; payload bytes are not reset.
module range_report_frame_parser_unit
  import rrfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               frame_ok_o,
  output logic signed [15:0] elevation_o,
  output logic signed [15:0] slant_distance_o,
  output logic signed [15:0] sine_height_o,
  output logic signed [15:0] horizontal_range_o,
  output logic signed [15:0] two_point_height_o,
  output logic signed [15:0] azimuth_o,
  output logic signed [15:0] horizontal_angle_o,
  output logic signed [15:0] span_value_o,
  output logic signed [15:0] velocity_o,
  output logic [7:0]         unit_code_o
);

  pos_t  pos_q, pos_d;
  byte_t sum_q, sum_d;
  byte_t len_q, len_d;
  byte_t chk_q, chk_d;
  logic  good_q, good_d;
  byte_t payload_q [PayloadCount];

  logic       in_fire;
  logic       frame_end;
  logic       frame_ok;
  logic [8:0] chk_pos;
  pos_t       pay_idx;
  logic       out_valid_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign frame_end  = (pos_q == POS_TRL1);
  assign chk_pos    = {1'b0, len_q} + 9'd2;
  assign pay_idx    = pos_q - POS_PAY_FIRST;

  always_comb begin
    pos_d  = pos_q + 5'd1;
    sum_d  = sum_q;
    len_d  = len_q;
    chk_d  = chk_q;
    good_d = good_q;
    case (pos_q)
      POS_HDR0: begin
        if (rx_byte_i != HDR0_BYTE) good_d = 1'b0;
      end
      POS_HDR1: begin
        if (rx_byte_i != HDR1_BYTE) good_d = 1'b0;
      end
      POS_LEN: begin
        len_d = rx_byte_i;
        sum_d = rx_byte_i;
        if (rx_byte_i < LEN_MIN || rx_byte_i > LEN_MAX) good_d = 1'b0;
      end
      POS_ADDR: begin
        sum_d = sum_q + rx_byte_i;
      end
      POS_CMD: begin
        sum_d = sum_q + rx_byte_i;
        if (rx_byte_i != CMD_RANGE) good_d = 1'b0;
      end
      POS_TRL0: begin
        if (rx_byte_i != TRL0_BYTE) good_d = 1'b0;
      end
      POS_TRL1: begin
        if (rx_byte_i != TRL1_BYTE) good_d = 1'b0;
      end
      default: begin
      end
    endcase
    // Bytes before the checksum position add in; the one at it is captured.
    if (pos_q inside {[POS_PAY_FIRST:POS_SUM_LAST]}) begin
      if ({4'd0, pos_q} < chk_pos) begin
        sum_d = sum_q + rx_byte_i;
      end else if ({4'd0, pos_q} == chk_pos) begin
        chk_d = rx_byte_i;
      end
    end
  end

  // The trailer check lands in good_d; sum and check byte are final by now.
  assign frame_ok = good_d && (sum_q == chk_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_HDR0;
      sum_q  <= '0;
      len_q  <= '0;
      chk_q  <= '0;
      good_q <= 1'b1;
    end else if (in_fire) begin
      if (frame_end) begin
        pos_q  <= POS_HDR0;
        sum_q  <= '0;
        len_q  <= '0;
        chk_q  <= '0;
        good_q <= 1'b1;
      end else begin
        pos_q  <= pos_d;
        sum_q  <= sum_d;
        len_q  <= len_d;
        chk_q  <= chk_d;
        good_q <= good_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (pos_q inside {[POS_PAY_FIRST:POS_PAY_LAST]})) begin
      payload_q[pay_idx] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && frame_end) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // A rejected frame reports all fields as zero.
  always_ff @(posedge clk_i) begin
    if (in_fire && frame_end) begin
      frame_ok_o <= frame_ok;
      if (frame_ok) begin
        elevation_o        <= {payload_q[0],  payload_q[1]};
        slant_distance_o   <= {payload_q[2],  payload_q[3]};
        sine_height_o      <= {payload_q[4],  payload_q[5]};
        horizontal_range_o <= {payload_q[6],  payload_q[7]};
        two_point_height_o <= {payload_q[8],  payload_q[9]};
        azimuth_o          <= {payload_q[10], payload_q[11]};
        horizontal_angle_o <= {payload_q[12], payload_q[13]};
        span_value_o       <= {payload_q[14], payload_q[15]};
        velocity_o         <= {payload_q[16], payload_q[17]};
        unit_code_o        <= payload_q[18];
      end else begin
        elevation_o        <= '0;
        slant_distance_o   <= '0;
        sine_height_o      <= '0;
        horizontal_range_o <= '0;
        two_point_height_o <= '0;
        azimuth_o          <= '0;
        horizontal_angle_o <= '0;
        span_value_o       <= '0;
        velocity_o         <= '0;
        unit_code_o        <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/rrfp_checker.sv -----
// Port-level checker for the range report frame parser, bound to the top.
// Depends only on the top level's ports.
module rrfp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [7:0]         rx_byte_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               frame_ok_o,
  input logic signed [15:0] elevation_o,
  input logic signed [15:0] slant_distance_o,
  input logic signed [15:0] sine_height_o,
  input logic signed [15:0] horizontal_range_o,
  input logic signed [15:0] two_point_height_o,
  input logic signed [15:0] azimuth_o,
  input logic signed [15:0] horizontal_angle_o,
  input logic signed [15:0] span_value_o,
  input logic signed [15:0] velocity_o,
  input logic [7:0]         unit_code_o
);

  // A waiting result stays valid; its flag, unit code and elevation hold until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_ok_o)
      && $stable(unit_code_o) && $stable(elevation_o))
    else $error("result changed while stalled");

  // A stalled result blocks the input side.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input ready while result stalled");

  // A new result only follows an accepted input beat.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result without input beat");

  // A rejected frame reports zero unit code, elevation, velocity and azimuth.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_ok_o |-> unit_code_o == 8'd0 && elevation_o == 16'sd0
      && velocity_o == 16'sd0 && azimuth_o == 16'sd0)
    else $error("rejected frame with nonzero fields");

endmodule

bind range_report_frame_parser_unit rrfp_checker u_rrfp_checker (.*);
